// ----- design/bmhq_pkg.sv -----
// ============================================================================
// bmhq_pkg
// Shared types, codes and the sequencer microprogram of the min-heap queue.
// ============================================================================
package bmhq_pkg;

    // Default heap capacity in entries
    localparam int DEF_HEAP_DEPTH = 1024;

    // Field widths of one entry
    localparam int TAG_W  = 20;
    localparam int COST_W = 16;
    localparam int KEY_W  = 16;
    localparam int FILL_W = 11;
    localparam int STAT_W = 2;

    // Stream payload widths (byte-padded)
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // One heap entry
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [COST_W-1:0] cost;
        logic [KEY_W-1:0]  key;
    } entry_t;

    // Datapath operations driven by the control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,      // capture the command, check full/empty
        OP_PUSH_INIT,  // pos = count, count++
        OP_RD_PARENT,  // read parent of pos
        OP_UP_MOVE,    // parent moves down into pos when new key is smaller
        OP_PLACE,      // write the moving entry at pos
        OP_RD_ROOT,    // read root, count--
        OP_RD_LAST,    // read last slot, capture root as result
        OP_LOAD_LAST,  // moving entry = last slot, pos = root
        OP_RD_LEFT,    // read left child of pos
        OP_RD_RIGHT,   // read right child, rank left child against moving entry
        OP_DN_MOVE,    // smaller child moves up into pos
        OP_EMIT        // hand the result to the output register
    } op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ACCEPT,
        C_REFUSED,
        C_IS_POP,
        C_AT_ROOT,
        C_UP_LESS,
        C_NO_CHILD,
        C_DN_MORE,
        C_OUT_FREE
    } cond_t;

    localparam int STEP_W = 4;

    // One microinstruction
    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic refused;
        logic is_pop;
        logic at_root;
        logic up_less;
        logic no_child;
        logic dn_more;
    } dp_flags_t;

    // Microprogram step addresses
    localparam logic [STEP_W-1:0] S_IDLE      = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_CHECK     = STEP_W'(1);
    localparam logic [STEP_W-1:0] S_DISPATCH  = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_PUSH      = STEP_W'(3);
    localparam logic [STEP_W-1:0] S_UP_RD     = STEP_W'(4);
    localparam logic [STEP_W-1:0] S_UP_CMP    = STEP_W'(5);
    localparam logic [STEP_W-1:0] S_PLACE_UP  = STEP_W'(6);
    localparam logic [STEP_W-1:0] S_POP_ROOT  = STEP_W'(7);
    localparam logic [STEP_W-1:0] S_POP_LAST  = STEP_W'(8);
    localparam logic [STEP_W-1:0] S_POP_LOAD  = STEP_W'(9);
    localparam logic [STEP_W-1:0] S_DN_RDL    = STEP_W'(10);
    localparam logic [STEP_W-1:0] S_DN_RDR    = STEP_W'(11);
    localparam logic [STEP_W-1:0] S_DN_CMP    = STEP_W'(12);
    localparam logic [STEP_W-1:0] S_PLACE_DN  = STEP_W'(13);
    localparam logic [STEP_W-1:0] S_EMIT      = STEP_W'(14);
    localparam logic [STEP_W-1:0] S_EMIT_WAIT = STEP_W'(15);

    // Microprogram ROM: jump to target when cond holds, else fall through
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        unique case (step)
            S_IDLE:      w = '{OP_LATCH,     C_NO_ACCEPT, S_IDLE};
            S_CHECK:     w = '{OP_NOP,       C_REFUSED,   S_EMIT};
            S_DISPATCH:  w = '{OP_NOP,       C_IS_POP,    S_POP_ROOT};
            S_PUSH:      w = '{OP_PUSH_INIT, C_NEVER,     S_IDLE};
            S_UP_RD:     w = '{OP_RD_PARENT, C_AT_ROOT,   S_PLACE_UP};
            S_UP_CMP:    w = '{OP_UP_MOVE,   C_UP_LESS,   S_UP_RD};
            S_PLACE_UP:  w = '{OP_PLACE,     C_ALWAYS,    S_EMIT};
            S_POP_ROOT:  w = '{OP_RD_ROOT,   C_NEVER,     S_IDLE};
            S_POP_LAST:  w = '{OP_RD_LAST,   C_NEVER,     S_IDLE};
            S_POP_LOAD:  w = '{OP_LOAD_LAST, C_NEVER,     S_IDLE};
            S_DN_RDL:    w = '{OP_RD_LEFT,   C_NO_CHILD,  S_PLACE_UP};
            S_DN_RDR:    w = '{OP_RD_RIGHT,  C_NEVER,     S_IDLE};
            S_DN_CMP:    w = '{OP_DN_MOVE,   C_DN_MORE,   S_DN_RDL};
            S_PLACE_DN:  w = '{OP_PLACE,     C_NEVER,     S_IDLE};
            S_EMIT:      w = '{OP_EMIT,      C_OUT_FREE,  S_IDLE};
            S_EMIT_WAIT: w = '{OP_NOP,       C_ALWAYS,    S_EMIT};
            default:     w = '{OP_NOP,       C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- design/bmhq_seq.sv -----
// ============================================================================
// bmhq_seq
// Microprogram sequencer: step counter, ROM lookup and conditional jumps.
// ============================================================================
module bmhq_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  out_free,
    input  bmhq_pkg::dp_flags_t   flags,
    output bmhq_pkg::ctrl_word_t  ctrl,
    output logic                  idle
);

    logic [bmhq_pkg::STEP_W-1:0] upc_reg;
    logic [bmhq_pkg::STEP_W-1:0] upc_next;
    logic                        take;

    // Current control word
    assign ctrl = bmhq_pkg::ucode(upc_reg);
    assign idle = (upc_reg == bmhq_pkg::S_IDLE);

    // Jump condition select
    always_comb
    begin
        unique case (ctrl.cond)
            bmhq_pkg::C_NEVER:     take = 1'b0;
            bmhq_pkg::C_ALWAYS:    take = 1'b1;
            bmhq_pkg::C_NO_ACCEPT: take = !accept;
            bmhq_pkg::C_REFUSED:   take = flags.refused;
            bmhq_pkg::C_IS_POP:    take = flags.is_pop;
            bmhq_pkg::C_AT_ROOT:   take = flags.at_root;
            bmhq_pkg::C_UP_LESS:   take = flags.up_less;
            bmhq_pkg::C_NO_CHILD:  take = flags.no_child;
            bmhq_pkg::C_DN_MORE:   take = flags.dn_more;
            bmhq_pkg::C_OUT_FREE:  take = out_free;
            default:               take = 1'b0;
        endcase
        upc_next = take ? ctrl.target : upc_reg + bmhq_pkg::STEP_W'(1);
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= bmhq_pkg::S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- design/bmhq_dpath.sv -----
// ============================================================================
// bmhq_dpath
// Heap datapath: entry memory, count, position and moving-entry registers.
// ============================================================================
module bmhq_dpath #(
    parameter int HEAP_DEPTH = bmhq_pkg::DEF_HEAP_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bmhq_pkg::ctrl_word_t       ctrl,
    input  logic                       accept,
    input  logic                       in_cmd,
    input  bmhq_pkg::entry_t           in_entry,
    output bmhq_pkg::dp_flags_t        flags,
    output logic [bmhq_pkg::STAT_W-1:0] res_status,
    output bmhq_pkg::entry_t           res_entry,
    output logic [bmhq_pkg::FILL_W-1:0] res_fill
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = AW + 2;

    // Entry storage
    bmhq_pkg::entry_t heap_mem [HEAP_DEPTH];
    bmhq_pkg::entry_t rd_data_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    bmhq_pkg::entry_t wr_data;

    // Control and working registers
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [AW-1:0]    pos_reg;
    logic [AW-1:0]    pos_next;
    bmhq_pkg::entry_t cur_reg;
    bmhq_pkg::entry_t cur_next;
    bmhq_pkg::entry_t best_reg;
    bmhq_pkg::entry_t best_next;
    logic             left_won_reg;
    logic             left_won_next;
    logic             cmd_reg;
    logic             cmd_next;
    logic [bmhq_pkg::STAT_W-1:0] status_reg;
    logic [bmhq_pkg::STAT_W-1:0] status_next;
    bmhq_pkg::entry_t res_reg;
    bmhq_pkg::entry_t res_next;

    // Tree indexes
    logic [AW-1:0] parent;
    logic [IW-1:0] left_idx;
    logic [IW-1:0] right_idx;
    logic [IW-1:0] count_x;
    logic          right_ok;
    logic          right_lt;
    logic          left_lt;

    assign parent    = (pos_reg - AW'(1)) >> 1;
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + IW'(1);
    assign count_x   = IW'(count_reg);
    assign right_ok  = right_idx < count_x;
    assign left_lt   = rd_data_reg.key < cur_reg.key;
    assign right_lt  = right_ok && (rd_data_reg.key < best_reg.key);

    // Flags to the sequencer
    assign flags.refused  = (status_reg != bmhq_pkg::ST_OK);
    assign flags.is_pop   = (cmd_reg == bmhq_pkg::CMD_POP);
    assign flags.at_root  = (pos_reg == '0);
    assign flags.up_less  = cur_reg.key < rd_data_reg.key;
    assign flags.no_child = left_idx >= count_x;
    assign flags.dn_more  = right_lt || left_won_reg;

    assign res_status = status_reg;
    assign res_entry  = res_reg;
    assign res_fill   = bmhq_pkg::FILL_W'(count_reg);

    // Operation decode
    always_comb
    begin
        rd_en         = 1'b0;
        rd_addr       = pos_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = cur_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        left_won_next = left_won_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        res_next      = res_reg;
        unique case (ctrl.op)
            bmhq_pkg::OP_NOP,
            bmhq_pkg::OP_EMIT:
            begin
            end
            bmhq_pkg::OP_LATCH:
            begin
                if (accept)
                begin
                    cmd_next = in_cmd;
                    cur_next = in_entry;
                    res_next = '0;
                    if (in_cmd == bmhq_pkg::CMD_PUSH && count_reg == CW'(HEAP_DEPTH))
                        status_next = bmhq_pkg::ST_FULL;
                    else if (in_cmd == bmhq_pkg::CMD_POP && count_reg == '0)
                        status_next = bmhq_pkg::ST_EMPTY;
                    else
                        status_next = bmhq_pkg::ST_OK;
                end
            end
            bmhq_pkg::OP_PUSH_INIT:
            begin
                pos_next   = count_reg[AW-1:0];
                count_next = count_reg + CW'(1);
            end
            bmhq_pkg::OP_RD_PARENT:
            begin
                rd_en   = 1'b1;
                rd_addr = parent;
            end
            bmhq_pkg::OP_UP_MOVE:
            begin
                if (flags.up_less)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data_reg;
                    pos_next = parent;
                end
            end
            bmhq_pkg::OP_PLACE:
            begin
                wr_en = 1'b1;
            end
            bmhq_pkg::OP_RD_ROOT:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                count_next = count_reg - CW'(1);
            end
            bmhq_pkg::OP_RD_LAST:
            begin
                rd_en    = 1'b1;
                rd_addr  = count_reg[AW-1:0];
                res_next = rd_data_reg;
            end
            bmhq_pkg::OP_LOAD_LAST:
            begin
                cur_next = rd_data_reg;
                pos_next = '0;
            end
            bmhq_pkg::OP_RD_LEFT:
            begin
                rd_en   = 1'b1;
                rd_addr = left_idx[AW-1:0];
            end
            bmhq_pkg::OP_RD_RIGHT:
            begin
                rd_en         = 1'b1;
                rd_addr       = right_idx[AW-1:0];
                left_won_next = left_lt;
                best_next     = left_lt ? rd_data_reg : cur_reg;
            end
            bmhq_pkg::OP_DN_MOVE:
            begin
                // right wins only on a strictly smaller key than the best so far
                if (right_lt)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data_reg;
                    pos_next = right_idx[AW-1:0];
                end
                else if (left_won_reg)
                begin
                    wr_en    = 1'b1;
                    wr_data  = best_reg;
                    pos_next = left_idx[AW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            heap_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= heap_mem[rd_addr];
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        left_won_reg <= left_won_next;
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
    end

endmodule

// ----- design/binary_min_heap_queue_top.sv -----
// ============================================================================
// binary_min_heap_queue_top
// Binary min-heap priority queue of tag/cost/key entries, microcoded control.
// ============================================================================
// Usage:
//   The slave stream carries commands: tuser is the command (push or pop),
//   tdata the entry to push. Every command yields exactly one result
//   transaction on the master stream: tuser is the status (done, refused
//   full, refused empty), tdata the popped entry (zero unless a pop is done)
//   and the fill level after the command.
//   One command is in work at a time; s_axis_tready is high only while the
//   sequencer waits in its idle step, also while a result is still held.
//   Work per command, for k levels moved:
//     push: one memory read and one compare per level.
//     pop:  two child reads and one compare per level on the one read port.
//     refused command: goes straight from the check to the result, no heap access.
//   The input reopens in the cycle the result turns valid; the heap depth bounds
//   the levels moved, and all heap reads share the one read port.
//   Reset empties the heap at once (count cleared, no sweep of the memory).
//   When the receiver stalls, the result stays in the output register and
//   the sequencer waits before emitting the next one.
// ============================================================================
module binary_min_heap_queue_top #(
    parameter int HEAP_DEPTH = bmhq_pkg::DEF_HEAP_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [19:0] item_tag, [35:20] item_cost, [51:36] item_key, [55:52] zero
    input  logic [bmhq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] cmd
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [19:0] out_tag, [35:20] out_cost, [51:36] out_key, [62:52] fill, [63] zero
    output logic [bmhq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [bmhq_pkg::STAT_W-1:0]       m_axis_tuser
);

    bmhq_pkg::ctrl_word_t ctrl;
    bmhq_pkg::dp_flags_t  flags;
    bmhq_pkg::entry_t     in_entry;
    bmhq_pkg::entry_t     res_entry;
    logic [bmhq_pkg::STAT_W-1:0] res_status;
    logic [bmhq_pkg::FILL_W-1:0] res_fill;
    logic                 idle;
    logic                 accept;
    logic                 out_free;
    logic                 emit;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [bmhq_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic [bmhq_pkg::OUT_DATA_W-1:0]  out_data_next;
    logic [bmhq_pkg::STAT_W-1:0]      out_user_reg;
    logic [bmhq_pkg::STAT_W-1:0]      out_user_next;

    // Input unpacking and handshake
    assign in_entry.tag  = s_axis_tdata[19:0];
    assign in_entry.cost = s_axis_tdata[35:20];
    assign in_entry.key  = s_axis_tdata[51:36];
    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && idle;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign emit     = (ctrl.op == bmhq_pkg::OP_EMIT) && out_free;

    bmhq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .out_free (out_free),
        .flags    (flags),
        .ctrl     (ctrl),
        .idle     (idle)
    );

    bmhq_dpath #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .accept     (accept),
        .in_cmd     (s_axis_tuser),
        .in_entry   (in_entry),
        .flags      (flags),
        .res_status (res_status),
        .res_entry  (res_entry),
        .res_fill   (res_fill)
    );

    // Output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, res_fill, res_entry.key, res_entry.cost, res_entry.tag};
            out_user_next  = res_status;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ----- design/bmhq_checker.sv -----
// ============================================================================
// bmhq_checker
// Port-level checks of the min-heap queue, bound to the top level.
// ============================================================================
module bmhq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bmhq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [bmhq_pkg::STAT_W-1:0]     m_axis_tuser
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Only one command in work: acceptance closes the input
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command accepted while busy");

    // Status is a defined code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == bmhq_pkg::ST_OK ||
                           m_axis_tuser == bmhq_pkg::ST_FULL ||
                           m_axis_tuser == bmhq_pkg::ST_EMPTY))
        else $error("undefined status code");

    // Refused commands carry no entry
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != bmhq_pkg::ST_OK |-> m_axis_tdata[51:0] == '0)
        else $error("refused command returned an entry");

    // Empty refusal reports an empty heap
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == bmhq_pkg::ST_EMPTY |-> m_axis_tdata[62:52] == '0)
        else $error("empty refusal with nonzero fill");

endmodule

bind binary_min_heap_queue_top bmhq_checker u_bmhq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
